// ----- rtl/gsfs_pkg.sv -----
// gsfs_pkg: shared types and constants of the grid sensor footprint scan
// used by gsfs_ctrl, gsfs_dp and grid_sensor_footprint_scan
`default_nettype none

package gsfs_pkg;

    // default design parameters
    localparam int MAX_RADIUS_DEF = 3;
    localparam int COORD_BITS_DEF = 12;

    // fixed field widths
    localparam int FIELD_BITS = 12;
    localparam int CFG_BITS   = 13;
    localparam int RAD_BITS   = 6;
    localparam int MODE_BITS  = 2;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_RADIUS      = 2'd2,
        REG_MODE        = 2'd3
    } cfg_reg_t;

    // distance metric codes
    localparam logic [MODE_BITS-1:0] MODE_CHEBYSHEV = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_MANHATTAN = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_EUCLIDEAN = 2'd2;

    // reset values of the configuration registers
    localparam logic [CFG_BITS-1:0]  GRID_WIDTH_RST  = 13'd4096;
    localparam logic [CFG_BITS-1:0]  GRID_HEIGHT_RST = 13'd4096;
    localparam logic [RAD_BITS-1:0]  RADIUS_RST      = 6'd16;
    localparam logic [MODE_BITS-1:0] MODE_RST        = MODE_EUCLIDEAN;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;        // latch center, set up window
        logic step;        // advance to the next offset
        logic capture;     // hold current cell as pending result
        logic emit_pend;   // push pending cell to output, not last
        logic emit_final;  // push pending cell as last, or empty item
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic keep;        // current offset is a visible cell
        logic scan_end;    // current offset is the last of the window
        logic slot_free;   // output register can take an item
        logic have_pend;   // a pending result is held
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/gsfs_ctrl.sv -----
// gsfs_ctrl: scan controller of the grid sensor footprint scan
// depends on gsfs_pkg (state_t, cmd_t, status_t)
`default_nettype none

module gsfs_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire gsfs_pkg::status_t status,
    output gsfs_pkg::cmd_t        cmd
);
    import gsfs_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.scan_end &&
                    (!status.keep || !status.have_pend || status.slot_free)) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (status.slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SCAN: begin
                if (!status.keep) begin
                    cmd.step = 1'b1;
                end else if (!status.have_pend) begin
                    cmd.capture = 1'b1;
                    cmd.step    = 1'b1;
                end else if (status.slot_free) begin
                    cmd.emit_pend = 1'b1;
                    cmd.capture   = 1'b1;
                    cmd.step      = 1'b1;
                end
            end
            ST_FLUSH: begin
                cmd.emit_final = status.slot_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/gsfs_dp.sv -----
// gsfs_dp: datapath of the grid sensor footprint scan (offset counters,
// bounds and distance test, pending cell, output register); uses gsfs_pkg
`default_nettype none

module gsfs_dp #(
    parameter int MAX_RADIUS = gsfs_pkg::MAX_RADIUS_DEF,
    parameter int COORD_BITS = gsfs_pkg::COORD_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire gsfs_pkg::cmd_t                   cmd,
    output gsfs_pkg::status_t                     status,
    input  wire logic [gsfs_pkg::FIELD_BITS-1:0]  center_x,
    input  wire logic [gsfs_pkg::FIELD_BITS-1:0]  center_y,
    input  wire logic [gsfs_pkg::CFG_BITS-1:0]    grid_width,
    input  wire logic [gsfs_pkg::CFG_BITS-1:0]    grid_height,
    input  wire logic [gsfs_pkg::RAD_BITS-1:0]    radius_sixteenths,
    input  wire logic [gsfs_pkg::MODE_BITS-1:0]   distance_mode,
    input  wire logic                             out_ready,
    output logic                                  out_valid,
    output logic [gsfs_pkg::FIELD_BITS-1:0]       cell_x,
    output logic [gsfs_pkg::FIELD_BITS-1:0]       cell_y,
    output logic                                  empty_res,
    output logic                                  last
);
    import gsfs_pkg::*;

    localparam int OW = $clog2(MAX_RADIUS + 1) + 1;
    localparam int PW = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 2;
    localparam int DW = OW + 2 * RAD_BITS;
    localparam logic [PW-1:0] SPAN  = PW'(1) << COORD_BITS;
    localparam logic [PW-1:0] CMASK = SPAN - PW'(1);

    // scan state
    logic        [PW-1:0]         cx_reg, cy_reg;
    logic signed [OW-1:0]         half_reg, dx_reg, dy_reg;
    logic        [FIELD_BITS-1:0] pend_x_reg, pend_y_reg;
    logic                         pend_valid_reg;

    // output register
    logic                  out_valid_reg;
    logic [FIELD_BITS-1:0] out_x_reg, out_y_reg;
    logic                  out_empty_reg, out_last_reg;

    logic [RAD_BITS:0]            half_raw;
    logic signed [OW-1:0]         half_sat;
    logic signed [PW-1:0]         px, py;
    logic        [PW-1:0]         pxu, pyu, wc, hc;
    logic                         on_grid;
    logic        [OW-1:0]         ax, ay, amax;
    logic        [DW-1:0]         d_cheb, d_manh, d_sq, r_lin, r_sq;
    logic                         dist_ok;
    logic                         slot_free;
    logic                         emit;

    // window half-size: ceil(radius / 16) saturated at the window limit
    always_comb begin
        half_raw = ({1'b0, radius_sixteenths} + (RAD_BITS + 1)'(15)) >> 4;
        if (half_raw > (RAD_BITS + 1)'(MAX_RADIUS)) begin
            half_sat = OW'(MAX_RADIUS);
        end else begin
            half_sat = OW'(half_raw);
        end
    end

    // candidate cell and grid bounds, extents clipped to the coordinate span
    always_comb begin
        px  = $signed(cx_reg) + PW'(dx_reg);
        py  = $signed(cy_reg) + PW'(dy_reg);
        pxu = px;
        pyu = py;
        wc  = (PW'(grid_width) > SPAN) ? SPAN : PW'(grid_width);
        hc  = (PW'(grid_height) > SPAN) ? SPAN : PW'(grid_height);
        on_grid = !px[PW-1] && !py[PW-1] && (pxu < wc) && (pyu < hc);
    end

    // distance test in sixteenths
    always_comb begin
        ax     = dx_reg[OW-1] ? OW'(-dx_reg) : OW'(dx_reg);
        ay     = dy_reg[OW-1] ? OW'(-dy_reg) : OW'(dy_reg);
        amax   = (ax > ay) ? ax : ay;
        d_cheb = DW'(amax) << 4;
        d_manh = (DW'(ax) + DW'(ay)) << 4;
        d_sq   = (DW'(ax) * DW'(ax) + DW'(ay) * DW'(ay)) << 8;
        r_lin  = DW'(radius_sixteenths);
        r_sq   = DW'(radius_sixteenths) * DW'(radius_sixteenths);
        case (distance_mode)
            MODE_CHEBYSHEV: dist_ok = (d_cheb <= r_lin);
            MODE_MANHATTAN: dist_ok = (d_manh <= r_lin);
            default:        dist_ok = (d_sq <= r_sq);
        endcase
    end

    assign slot_free = !out_valid_reg || out_ready;
    assign emit      = cmd.emit_pend || cmd.emit_final;

    // status to the controller
    always_comb begin
        status.keep      = on_grid && dist_ok;
        status.scan_end  = (dx_reg == half_reg) && (dy_reg == half_reg);
        status.slot_free = slot_free;
        status.have_pend = pend_valid_reg;
    end

    // control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.load || cmd.emit_final) begin
                pend_valid_reg <= 1'b0;
            end else if (cmd.capture) begin
                pend_valid_reg <= 1'b1;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // center, offsets and window size
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cx_reg   <= PW'(center_x) & CMASK;
            cy_reg   <= PW'(center_y) & CMASK;
            half_reg <= half_sat;
            dx_reg   <= -half_sat;
            dy_reg   <= -half_sat;
        end else if (cmd.step) begin
            if (dx_reg == half_reg) begin
                dx_reg <= -half_reg;
                dy_reg <= dy_reg + OW'(1);
            end else begin
                dx_reg <= dx_reg + OW'(1);
            end
        end
    end

    // pending cell and output payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            pend_x_reg <= pxu[FIELD_BITS-1:0];
            pend_y_reg <= pyu[FIELD_BITS-1:0];
        end
        if (cmd.emit_pend) begin
            out_x_reg     <= pend_x_reg;
            out_y_reg     <= pend_y_reg;
            out_empty_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end else if (cmd.emit_final) begin
            out_x_reg     <= pend_valid_reg ? pend_x_reg : '0;
            out_y_reg     <= pend_valid_reg ? pend_y_reg : '0;
            out_empty_reg <= !pend_valid_reg;
            out_last_reg  <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign cell_x    = out_x_reg;
    assign cell_y    = out_y_reg;
    assign empty_res = out_empty_reg;
    assign last      = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/grid_sensor_footprint_scan.sv -----
// grid_sensor_footprint_scan: top level, configuration registers and stream ports
// depends on gsfs_pkg, gsfs_ctrl and gsfs_dp
// the window holds (2r+1)^2 candidate cells, r = window half-size; results leave through an output register
// one item at a time: a new item is taken only once the previous scan has flushed its final result,
//   and the offset scan tests one candidate cell per cycle while the output register is not stalled
// reset: synchronous active-low aresetn; registers return to 4096, 4096, 16, Euclidean
`default_nettype none

module grid_sensor_footprint_scan #(
    parameter int MAX_RADIUS = gsfs_pkg::MAX_RADIUS_DEF,
    parameter int COORD_BITS = gsfs_pkg::COORD_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [1:0]                      cfg_index,
    input  wire logic [gsfs_pkg::CFG_BITS-1:0]   cfg_data,
    // input items
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [2*gsfs_pkg::FIELD_BITS-1:0] s_tdata,  // center_x, center_y
    // result items
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [2*gsfs_pkg::FIELD_BITS-1:0]    m_tdata,    // cell_x, cell_y
    output logic                                 m_tuser,    // empty_res
    output logic                                 m_tlast
);
    import gsfs_pkg::*;

    logic [CFG_BITS-1:0]   grid_width_reg, grid_height_reg;
    logic [RAD_BITS-1:0]   radius_reg;
    logic [MODE_BITS-1:0]  mode_reg;
    cmd_t                  cmd;
    status_t               status;
    logic [FIELD_BITS-1:0] cell_x, cell_y;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= GRID_WIDTH_RST;
            grid_height_reg <= GRID_HEIGHT_RST;
            radius_reg      <= RADIUS_RST;
            mode_reg        <= MODE_RST;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                REG_RADIUS:      radius_reg      <= cfg_data[RAD_BITS-1:0];
                REG_MODE:        mode_reg        <= cfg_data[MODE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // scan controller
    gsfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    gsfs_dp #(
        .MAX_RADIUS (MAX_RADIUS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .center_x          (s_tdata[FIELD_BITS-1:0]),
        .center_y          (s_tdata[2*FIELD_BITS-1:FIELD_BITS]),
        .grid_width        (grid_width_reg),
        .grid_height       (grid_height_reg),
        .radius_sixteenths (radius_reg),
        .distance_mode     (mode_reg),
        .out_ready         (m_tready),
        .out_valid         (m_tvalid),
        .cell_x            (cell_x),
        .cell_y            (cell_y),
        .empty_res         (m_tuser),
        .last              (m_tlast)
    );

    assign m_tdata = {cell_y, cell_x};

    // an empty item is the only and final one, with zero coordinates
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
        else $error("empty item not last or not zero");

    // a reported cell lies inside the grid width
    a_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |->
            (CFG_BITS'(m_tdata[FIELD_BITS-1:0]) < grid_width_reg))
        else $error("reported cell outside grid");

    // a taken item starts a scan, so no item is taken in the next cycle
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken during a scan");

endmodule

`default_nettype wire
